// ----- src/gpc_pkg.sv -----
// Package for the GPIO pin configuration register bank.
// Holds the bank sizes, status and pin mode codes, and the per-port pin count table.
// No dependencies.
package gpc_pkg;

  localparam int unsigned NumPorts    = 9;
  localparam int unsigned BankPorts   = 9;
  localparam int unsigned ActivePorts = (NumPorts < BankPorts) ? NumPorts : BankPorts;
  localparam int unsigned PortW       = $clog2(BankPorts);
  localparam int unsigned CtrlW       = 32;
  localparam int unsigned DataW       = 23;
  localparam int unsigned PullW       = 16;

  typedef enum logic [2:0] {
    StOk,
    StBadPin,
    StNoPull,
    StNoInput,
    StNoFunc2,
    StBadPort
  } status_e;

  typedef enum logic [1:0] {
    ModeInput,
    ModeOutput,
    ModeFunc1,
    ModeFunc2
  } pin_mode_e;

  // Highest valid pin number of each port.
  function automatic logic [4:0] last_pin(logic [PortW-1:0] port);
    logic [4:0] lp;
    unique case (port)
      4'd0:    lp = 5'd22;
      4'd1:    lp = 5'd10;
      4'd2:    lp = 5'd15;
      4'd3:    lp = 5'd15;
      4'd4:    lp = 5'd15;
      4'd5:    lp = 5'd7;
      4'd6:    lp = 5'd15;
      4'd7:    lp = 5'd10;
      4'd8:    lp = 5'd12;
      default: lp = 5'd0;
    endcase
    return lp;
  endfunction

endpackage

// ----- src/gpio_pin_config_registers.sv -----
// Top level of the GPIO pin configuration register bank.
// Depends on gpc_pkg for bank sizes, status codes, mode codes and the pin count table.
//
// Requests arrive as words on the input channel (valid/ready). Each word either reads
// one pin (mode, data and pull) or sets one pin (mode, optional data, pull). Every
// request produces exactly one result word on the output channel (valid/ready)
// carrying a status code and, for a successful read, the pin's settings.
// A request is captured in an input register, checked and applied to the port
// words by one short read-modify-write once the output register is free or
// being read, and its result is loaded into the output register at that same edge.
// One request is accepted per cycle as long as the output side keeps taking
// results. When the receiver stalls, the result waits in the output register
// and one more request can still be accepted into the input register; only
// then does input ready drop. Reset clears all control, data and pull words
// to zero and empties both registers.
module gpio_pin_config_registers (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [3:0]           port_index_i,
  input  logic [4:0]           pin_index_i,
  input  logic [1:0]           pin_mode_i,
  input  logic                 drive_valid_i,
  input  logic                 drive_value_i,
  input  logic                 pull_enable_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [1:0]           mode_read_o,
  output logic                 data_read_o,
  output logic                 pull_read_o
);
  import gpc_pkg::*;

  logic             req_valid_q;
  logic             action_q;
  logic [3:0]       port_q;
  logic [4:0]       pin_q;
  logic [1:0]       mode_q;
  logic             drive_valid_q;
  logic             drive_value_q;
  logic             pull_enable_q;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [1:0]       mode_read_q;
  logic             data_read_q;
  logic             pull_read_q;

  logic [CtrlW-1:0] port_control_q      [BankPorts];
  logic [DataW-1:0] port_data_q         [BankPorts];
  logic [PullW-1:0] port_pull_disable_q [BankPorts];

  logic             advance;
  logic             port_ok;
  logic [PortW-1:0] idx;
  logic [4:0]       ctrl_sh;
  logic [CtrlW-1:0] ctrl_w;
  logic [DataW-1:0] data_w;
  logic [PullW-1:0] pull_w;
  logic [CtrlW-1:0] ctrl_d;
  logic [DataW-1:0] data_d;
  logic [PullW-1:0] pull_d;
  logic             wr_en;
  status_e          status_d;
  logic [1:0]       mode_read_d;
  logic             data_read_d;
  logic             pull_read_d;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  assign port_ok = 5'(port_q) < 5'(ActivePorts);
  assign idx     = port_q[PortW-1:0];
  assign ctrl_sh = {pin_q[3:0], 1'b0};
  assign ctrl_w  = port_control_q[idx];
  assign data_w  = port_data_q[idx];
  assign pull_w  = port_pull_disable_q[idx];

  always_comb begin
    status_d    = StOk;
    mode_read_d = 2'b00;
    data_read_d = 1'b0;
    pull_read_d = 1'b0;
    ctrl_d      = ctrl_w;
    data_d      = data_w;
    pull_d      = pull_w;
    wr_en       = 1'b0;
    if (!port_ok) begin
      status_d = StBadPort;
    end else if (pin_q > last_pin(idx)) begin
      status_d = StBadPin;
    end else if (!action_q) begin
      data_read_d = data_w[pin_q];
      if (idx == '0) begin
        mode_read_d = ctrl_w[pin_q] ? ModeFunc1 : ModeOutput;
      end else begin
        mode_read_d = ctrl_w[ctrl_sh +: 2];
        pull_read_d = ~pull_w[pin_q[3:0]];
      end
    end else if (idx == '0) begin
      if (pull_enable_q) begin
        status_d = StNoPull;
      end else if (pin_mode_e'(mode_q) == ModeInput) begin
        status_d = StNoInput;
      end else if (pin_mode_e'(mode_q) == ModeFunc2) begin
        status_d = StNoFunc2;
      end else begin
        ctrl_d[pin_q] = (pin_mode_e'(mode_q) == ModeFunc1);
        if (drive_valid_q) begin
          data_d[pin_q] = drive_value_q;
        end
        wr_en = 1'b1;
      end
    end else begin
      ctrl_d[ctrl_sh +: 2] = mode_q;
      if (drive_valid_q) begin
        data_d[pin_q] = drive_value_q;
      end
      pull_d[pin_q[3:0]] = ~pull_enable_q;
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < BankPorts; i++) begin
        port_control_q[i]      <= '0;
        port_data_q[i]         <= '0;
        port_pull_disable_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && wr_en) begin
        port_control_q[idx]      <= ctrl_d;
        port_data_q[idx]         <= data_d;
        port_pull_disable_q[idx] <= pull_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q      <= action_i;
      port_q        <= port_index_i;
      pin_q         <= pin_index_i;
      mode_q        <= pin_mode_i;
      drive_valid_q <= drive_valid_i;
      drive_value_q <= drive_value_i;
      pull_enable_q <= pull_enable_i;
    end
    if (advance) begin
      status_q    <= status_d;
      mode_read_q <= mode_read_d;
      data_read_q <= data_read_d;
      pull_read_q <= pull_read_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign mode_read_o = mode_read_q;
  assign data_read_o = data_read_q;
  assign pull_read_o = pull_read_q;

  // A failed request never reports pin settings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> mode_read_o == 2'b00 && !data_read_o && !pull_read_o)
    else $error("failed request carries read data");

  // Processing a request always leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request lost its result");

  // Port 0 has only 23 control bits in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_control_q[0][CtrlW-1:DataW] == '0)
    else $error("unused port 0 control bits written");

  // Port 0 has no pull resistors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_pull_disable_q[0] == '0)
    else $error("port 0 pull word written");

  // The port 0 data and control words do not change while the input register holds no request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |=> $stable(port_data_q[0]) && $stable(port_control_q[0]))
    else $error("port 0 changed without a request");

endmodule

// ----- dv/gpio_pin_config_registers_tb.sv -----
// Testbench for the GPIO pin configuration register bank: directed and random pin reads and sets
// on valid/ready channels, checked word by word against a predictor kept in this file.
// Depends on gpc_pkg and gpio_pin_config_registers.
`timescale 1ns / 1ps

module gpio_pin_config_registers_tb;
  import gpc_pkg::*;

  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_SET  = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 900;

  typedef struct packed {
    status_e   status;
    pin_mode_e mode;
    logic      data;
    logic      pull;
  } pin_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       action_i = 1'b0;
  logic [3:0] port_index_i = '0;
  logic [4:0] pin_index_i = '0;
  logic [1:0] pin_mode_i = '0;
  logic       drive_valid_i = 1'b0;
  logic       drive_value_i = 1'b0;
  logic       pull_enable_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [1:0] mode_read_o;
  logic       data_read_o;
  logic       pull_read_o;

  logic [CtrlW-1:0] port_ctrl     [BankPorts];
  logic [DataW-1:0] port_data     [BankPorts];
  logic [PullW-1:0] port_pull_dis [BankPorts];

  pin_result_t pending_results[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_stall_en = 1'b1;

  gpio_pin_config_registers dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .port_index_i,
    .pin_index_i,
    .pin_mode_i,
    .drive_valid_i,
    .drive_value_i,
    .pull_enable_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .mode_read_o,
    .data_read_o,
    .pull_read_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [4:0] top_pin(input logic [3:0] port);
    case (port)
      4'd0:    return 5'd22;
      4'd1:    return 5'd10;
      4'd5:    return 5'd7;
      4'd7:    return 5'd10;
      4'd8:    return 5'd12;
      default: return 5'd15;
    endcase
  endfunction

  function automatic pin_result_t model_pin_access(input logic act, input logic [3:0] port,
                                                   input logic [4:0] pin, input logic [1:0] mode,
                                                   input logic dv, input logic dval,
                                                   input logic pull);
    pin_result_t r;
    r = '{status: StOk, mode: ModeInput, data: 1'b0, pull: 1'b0};
    if (port >= ActivePorts) begin
      r.status = StBadPort;
    end else if (pin > top_pin(port)) begin
      r.status = StBadPin;
    end else if (act == ACT_READ) begin
      r.data = port_data[port][pin];
      if (port == 4'd0) begin
        r.mode = port_ctrl[0][pin] ? ModeFunc1 : ModeOutput;
      end else begin
        r.mode = pin_mode_e'(port_ctrl[port][2*pin +: 2]);
        r.pull = ~port_pull_dis[port][pin];
      end
    end else if (port == 4'd0) begin
      if (pull) begin
        r.status = StNoPull;
      end else if (pin_mode_e'(mode) == ModeInput) begin
        r.status = StNoInput;
      end else if (pin_mode_e'(mode) == ModeFunc2) begin
        r.status = StNoFunc2;
      end else begin
        port_ctrl[0][pin] = (pin_mode_e'(mode) == ModeFunc1);
        if (dv) port_data[0][pin] = dval;
      end
    end else begin
      port_ctrl[port][2*pin +: 2] = mode;
      if (dv) port_data[port][pin] = dval;
      port_pull_dis[port][pin] = ~pull;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : check_results
    pin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result word: status %0d mode %0d data %0d pull %0d",
                             status_o, mode_read_o, data_read_o, pull_read_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || mode_read_o !== want.mode ||
            data_read_o !== want.data || pull_read_o !== want.pull) begin
          note_fault($sformatf({"mismatch: expected status %0d mode %0d data %0d pull %0d,",
                                " got status %0d mode %0d data %0d pull %0d"},
                               want.status, want.mode, want.data, want.pull,
                               status_o, mode_read_o, data_read_o, pull_read_o));
        end
      end
    end
  end

  initial begin : drive_out_ready
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = 1'b1;
        if (rx_stall_en && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  task automatic issue_request(input logic act, input logic [3:0] port, input logic [4:0] pin,
                               input logic [1:0] mode, input logic dv, input logic dval,
                               input logic pull);
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    action_i      = act;
    port_index_i  = port;
    pin_index_i   = pin;
    pin_mode_i    = mode;
    drive_valid_i = dv;
    drive_value_i = dval;
    pull_enable_i = pull;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(model_pin_access(act, port, pin, mode, dv, dval, pull));
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    issue_request(ACT_READ, 4'd0, 5'd0, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_READ, 4'd0, 5'd22, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_READ, 4'd8, 5'd12, ModeFunc2, 1'b1, 1'b1, 1'b1);
    issue_request(ACT_READ, 4'd1, 5'd0, ModeInput, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_bad_address();
    issue_request(ACT_READ, 4'd9, 5'd0, ModeOutput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd15, 5'd0, ModeOutput, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_READ, 4'd0, 5'd23, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd0, 5'd31, ModeInput, 1'b1, 1'b1, 1'b1);
    issue_request(ACT_READ, 4'd5, 5'd8, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd8, 5'd13, ModeFunc1, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_SET, 4'd1, 5'd11, ModeOutput, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_port0_rules();
    issue_request(ACT_SET, 4'd0, 5'd3, ModeInput, 1'b1, 1'b1, 1'b1);
    issue_request(ACT_SET, 4'd0, 5'd3, ModeInput, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_SET, 4'd0, 5'd3, ModeFunc2, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_SET, 4'd0, 5'd3, ModeFunc1, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_READ, 4'd0, 5'd3, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd0, 5'd22, ModeOutput, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_READ, 4'd0, 5'd22, ModeInput, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_mode_extremes();
    issue_request(ACT_SET, 4'd8, 5'd12, ModeFunc2, 1'b1, 1'b1, 1'b0);
    issue_request(ACT_READ, 4'd8, 5'd12, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd2, 5'd15, ModeInput, 1'b1, 1'b1, 1'b1);
    issue_request(ACT_READ, 4'd2, 5'd15, ModeInput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_SET, 4'd2, 5'd15, ModeOutput, 1'b0, 1'b0, 1'b0);
    issue_request(ACT_READ, 4'd2, 5'd15, ModeInput, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic       act;
    logic [3:0] port;
    logic [4:0] pin;
    logic [1:0] mode;
    logic       pull;
    logic       dv;
    logic       dval;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idle_en  = ($urandom_range(0, 2) != 0);
        rx_stall_en = ($urandom_range(0, 2) != 0);
      end
      act  = 1'($urandom_range(0, 1));
      mode = 2'($urandom_range(0, 3));
      pull = 1'($urandom_range(0, 1));
      dv   = 1'($urandom_range(0, 1));
      dval = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 80) begin
        port = 4'($urandom_range(0, ActivePorts - 1));
        pin  = 5'($urandom_range(0, top_pin(port)));
        if (port == 4'd0 && $urandom_range(0, 9) < 7) begin
          pull = 1'b0;
          mode = $urandom_range(0, 1) ? ModeFunc1 : ModeOutput;
        end
      end else begin
        port = 4'($urandom_range(0, 15));
        pin  = 5'($urandom_range(0, 31));
      end
      issue_request(act, port, pin, mode, dv, dval, pull);
      if (tx_idle_en) pause_sender(gap_len());
    end
    pause_sender(1);
  endtask

  initial begin
    for (int i = 0; i < BankPorts; i++) begin
      port_ctrl[i]     = '0;
      port_data[i]     = '0;
      port_pull_dis[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_bad_address();
    test_port0_rules();
    test_mode_extremes();
    pause_sender(1);
    wait_results_done();
    test_random_traffic(RANDOM_WORDS);
    wait_results_done();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
